>>> rtl/tss_pkg.sv
// Package for the tick and sleep task scheduler.
// Holds field widths, action codes, reset constants and the controller command type.
// No dependencies.
package tss_pkg;

  localparam int ACTION_W      = 2;
  localparam int TICK_W        = 32;
  localparam int PRIO_W        = 8;
  localparam int PERIOD_W      = 8;
  localparam int CUR_IDX_W     = 2;
  localparam int TOTAL_W       = 3;

  localparam int TASK_SLOTS_DEF = 4;
  localparam logic [PERIOD_W-1:0] SLICE_PERIOD_RST = 8'd10;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK   = 2'd0,
    ACT_SLEEP  = 2'd1,
    ACT_REG    = 2'd2,
    ACT_SWITCH = 2'd3
  } action_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } tss_cmd_t;

endpackage

>>> rtl/tss_if.sv
// Valid/ready channel interfaces for scheduler action items and result items.
// Depends on tss_pkg for the field widths.
interface tss_in_if import tss_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [TICK_W-1:0]   sleep_ticks;
  logic [PRIO_W-1:0]   new_priority;

  modport source (output valid, action, sleep_ticks, new_priority, input ready);
  modport sink   (input valid, action, sleep_ticks, new_priority, output ready);
endinterface

interface tss_out_if import tss_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 switch_request;
  logic [CUR_IDX_W-1:0] current_index;
  logic [TOTAL_W-1:0]   task_total;
  logic [TICK_W-1:0]    tick_value;
  logic                 register_ok;

  modport source (output valid, switch_request, current_index, task_total, tick_value,
                  register_ok, input ready);
  modport sink   (input valid, switch_request, current_index, task_total, tick_value,
                  register_ok, output ready);
endinterface

>>> rtl/tss_ctrl.sv
// Controller of the scheduler: sequences capture, execute and result hand-off.
// Depends on tss_pkg for the command type.
module tss_ctrl import tss_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output tss_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_OUT
  } state_t;

  state_t state_r;
  logic   in_ready_r;
  logic   out_valid_r;
  logic   exec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_ready_r  <= 1'b0;
      out_valid_r <= 1'b0;
      exec_r      <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_ready_r && in_valid) begin
            state_r    <= ST_EXEC;
            in_ready_r <= 1'b0;
            exec_r     <= 1'b1;
          end else begin
            in_ready_r <= 1'b1;
          end
        end
        ST_EXEC: begin
          state_r     <= ST_OUT;
          exec_r      <= 1'b0;
          out_valid_r <= 1'b1;
        end
        ST_OUT: begin
          if (out_ready) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b0;
            in_ready_r  <= 1'b1;
          end
        end
        default: begin
          state_r     <= ST_IDLE;
          in_ready_r  <= 1'b0;
          out_valid_r <= 1'b0;
          exec_r      <= 1'b0;
        end
      endcase
    end
  end

  assign in_ready    = in_ready_r;
  assign out_valid   = out_valid_r;
  assign cmd.capture = in_ready_r & in_valid;
  assign cmd.exec    = exec_r;

  a_ready_valid_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready_r && out_valid_r))
    else $error("input ready and result valid are high together");

  a_capture_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> exec_r)
    else $error("captured item was not executed in the next cycle");

  a_exec_then_out: assert property (@(posedge clk) disable iff (!rst_n)
    exec_r |=> (out_valid_r && !exec_r))
    else $error("executed item did not produce a result");

endmodule

>>> rtl/tss_datapath.sv
// Datapath of the scheduler: task table, tick and slice counters, result register.
// Depends on tss_pkg; driven by commands from tss_ctrl.
module tss_datapath import tss_pkg::*; #(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tss_cmd_t             cmd,
  input  logic                 cfg_we,
  input  logic [PERIOD_W-1:0]  cfg_wdata,
  input  logic [ACTION_W-1:0]  in_action,
  input  logic [TICK_W-1:0]    in_sleep_ticks,
  output logic                 out_switch_request,
  output logic [CUR_IDX_W-1:0] out_current_index,
  output logic [TOTAL_W-1:0]   out_task_total,
  output logic [TICK_W-1:0]    out_tick_value,
  output logic                 out_register_ok
);

  localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CNT_W = $clog2(TASK_SLOTS + 1);

  action_t                       act_r;
  logic [TICK_W-1:0]             dly_r;

  logic [TASK_SLOTS-1:0]         blk_r,  blk_nxt;
  logic [TASK_SLOTS-1:0][TICK_W-1:0] wake_r, wake_nxt;
  logic [CNT_W-1:0]              cnt_r,  cnt_nxt;
  logic [IDX_W-1:0]              run_r,  run_nxt;
  logic [TICK_W-1:0]             tick_r, tick_nxt;
  logic [PERIOD_W-1:0]           slice_r, slice_nxt;
  logic [PERIOD_W-1:0]           period_r;

  logic                          req_r,   req_nxt;
  logic                          regok_r, regok_nxt;

  logic [TICK_W-1:0]             tick_inc;
  logic [TASK_SLOTS-1:0]         slot_live;
  logic [TASK_SLOTS-1:0]         wake_due;
  logic [TASK_SLOTS-1:0][TICK_W-1:0] wake_diff;
  logic [PERIOD_W:0]             slice_sum;
  logic                          slice_end;
  logic                          run_live;

  assign tick_inc  = tick_r + TICK_W'(1);
  assign slice_sum = {1'b0, slice_r} + (PERIOD_W+1)'(1);
  assign slice_end = slice_sum >= {1'b0, period_r};
  assign run_live  = CNT_W'(run_r) < cnt_r;

  always_comb begin
    for (int i = 0; i < TASK_SLOTS; i++) begin
      slot_live[i] = CNT_W'(i) < cnt_r;
      wake_diff[i] = tick_inc - wake_r[i];
      wake_due[i]  = slot_live[i] && blk_r[i] && !wake_diff[i][TICK_W-1];
    end
  end

  always_comb begin
    logic found;
    found     = 1'b0;
    blk_nxt   = blk_r;
    wake_nxt  = wake_r;
    cnt_nxt   = cnt_r;
    run_nxt   = run_r;
    tick_nxt  = tick_r;
    slice_nxt = slice_r;
    req_nxt   = 1'b0;
    regok_nxt = 1'b0;
    case (act_r)
      ACT_TICK: begin
        tick_nxt = tick_inc;
        blk_nxt  = blk_r & ~wake_due;
        if (slice_end) begin
          slice_nxt = '0;
        end else begin
          slice_nxt = slice_sum[PERIOD_W-1:0];
        end
        req_nxt = slice_end | (|wake_due);
      end
      ACT_SLEEP: begin
        if (run_live) begin
          blk_nxt[run_r]  = 1'b1;
          wake_nxt[run_r] = tick_r + dly_r;
        end
        req_nxt = 1'b1;
      end
      ACT_REG: begin
        if (cnt_r < CNT_W'(TASK_SLOTS)) begin
          blk_nxt[cnt_r[IDX_W-1:0]]  = 1'b0;
          wake_nxt[cnt_r[IDX_W-1:0]] = '0;
          cnt_nxt   = cnt_r + CNT_W'(1);
          regok_nxt = 1'b1;
        end
      end
      ACT_SWITCH: begin
        for (int i = 0; i < TASK_SLOTS; i++) begin
          if (!found && slot_live[i] && (IDX_W'(i) != run_r) && !blk_r[i]) begin
            run_nxt = IDX_W'(i);
            found   = 1'b1;
          end
        end
      end
      default: begin
        req_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= action_t'(in_action);
      dly_r <= in_sleep_ticks;
    end
    if (cmd.exec) begin
      blk_r   <= blk_nxt;
      wake_r  <= wake_nxt;
      req_r   <= req_nxt;
      regok_r <= regok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      run_r    <= '0;
      tick_r   <= '0;
      slice_r  <= '0;
      period_r <= SLICE_PERIOD_RST;
    end else begin
      if (cfg_we) begin
        period_r <= cfg_wdata;
      end
      if (cmd.exec) begin
        cnt_r   <= cnt_nxt;
        run_r   <= run_nxt;
        tick_r  <= tick_nxt;
        slice_r <= slice_nxt;
      end
    end
  end

  assign out_switch_request = req_r;
  assign out_current_index  = CUR_IDX_W'(run_r);
  assign out_task_total     = TOTAL_W'(cnt_r);
  assign out_tick_value     = tick_r;
  assign out_register_ok    = regok_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TASK_SLOTS))
    else $error("task count exceeds the table size");

  a_running_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W'(run_r) < cnt_r) || (run_r == '0))
    else $error("running task index points past the registered tasks");

  a_sleep_requests: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && act_r == ACT_SLEEP) |=> req_r)
    else $error("sleep item did not request a switch");

  a_count_only_on_reg: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && act_r != ACT_REG) |=> $stable(cnt_r))
    else $error("task count changed on an item that is not a register");

endmodule

>>> rtl/tick_sleep_task_scheduler_top.sv
// An item is accepted at a clock edge while in_ch.ready is high; the action is captured
// at that edge, the datapath updates the task table and counters in the following cycle,
// and the result becomes valid at the end of that execute cycle and holds until out_ch.ready takes
// it. The next item is accepted in the cycle after the result has been taken, so a new item
// is not taken while the last one is still in flight. The rate is set by the controller's capture, execute
// and hand-off sequence. in_ch.ready is low in reset and is first raised by the controller's idle state. The
// slice period register written through cfg_we takes effect on the next tick item.
// Top level of the scheduler; depends on tss_pkg, tss_if, tss_ctrl and tss_datapath.
module tick_sleep_task_scheduler_top import tss_pkg::*; #(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  tss_in_if.sink              in_ch,
  tss_out_if.source           out_ch,
  input  logic                cfg_we,
  input  logic [PERIOD_W-1:0] cfg_wdata
);

  tss_cmd_t cmd;

  tss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  tss_datapath #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_action          (in_ch.action),
    .in_sleep_ticks     (in_ch.sleep_ticks),
    .out_switch_request (out_ch.switch_request),
    .out_current_index  (out_ch.current_index),
    .out_task_total     (out_ch.task_total),
    .out_tick_value     (out_ch.tick_value),
    .out_register_ok    (out_ch.register_ok)
  );

endmodule
